FILE: rtl/ifb_pkg.sv
// ---------------------------------------------------------------------------
// ifb_pkg
// Shared types, codes and constants of the interleaved frame blitter.
// ---------------------------------------------------------------------------
package ifb_pkg;

   // raster operation applied to one frame store byte
   typedef enum logic [2:0] {
      FUNC_COPY   = 3'd0,
      FUNC_INVERT = 3'd1,
      FUNC_AND    = 3'd2,
      FUNC_OR     = 3'd3,
      FUNC_XOR    = 3'd4,
      FUNC_GLYPH  = 3'd5,
      FUNC_FILL   = 3'd6,
      FUNC_READ   = 3'd7
   } func_type;

   // register index, byte address divided by four
   typedef enum logic [1:0] {
      REG_MODE  = 2'd0,
      REG_INK   = 2'd1,
      REG_PAPER = 2'd2
   } csr_index_type;

   localparam int FRAME_BYTES_DEF = 32768;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int PIXEL_X_W   = 10;
   localparam int STEP_W      = 8;
   localparam int ROW_W       = 9;
   localparam int BYTE_W      = 8;
   localparam int RSP_ADDR_W  = 15;
   localparam int COLOUR_W    = 2;

   // unreduced address sum stays below 2**SUM_W
   localparam int SUM_W       = 16;
   localparam int BANK_SHIFT  = 13;
   localparam int LINE_W      = 8;

   localparam logic [SUM_W-1:0] MONO_OFFSET = 16'h0221;
   localparam logic [6:0]       MONO_LINE   = 7'd90;
   localparam logic [6:0]       COLOUR_LINE = 7'd80;

   // two-bit colour repeated over the four pixels of a byte
   function automatic logic [BYTE_W-1:0] rep_colour(input logic [COLOUR_W-1:0] c);
      rep_colour = {4{c}};
   endfunction

endpackage

FILE: rtl/ifb_req_if.sv
// ---------------------------------------------------------------------------
// ifb_req_if
// Request channel: one blit word per handshake.
// ---------------------------------------------------------------------------
interface ifb_req_if;
   import ifb_pkg::*;

   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [PIXEL_X_W-1:0] pixel_x;
   logic [STEP_W-1:0]    byte_step;
   logic [ROW_W-1:0]     row;
   logic [BYTE_W-1:0]    data_in;

   modport source (output valid, func, pixel_x, byte_step, row, data_in, input ready);
   modport sink   (input valid, func, pixel_x, byte_step, row, data_in, output ready);
endinterface

FILE: rtl/ifb_rsp_if.sv
// ---------------------------------------------------------------------------
// ifb_rsp_if
// Response channel: accessed address and the byte written or read.
// ---------------------------------------------------------------------------
interface ifb_rsp_if;
   import ifb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [RSP_ADDR_W-1:0] address;
   logic [BYTE_W-1:0]     data_out;
   logic                  wrote;

   modport source (output valid, address, data_out, wrote, input ready);
   modport sink   (input valid, address, data_out, wrote, output ready);
endinterface

FILE: rtl/interleaved_frame_blitter_unit.sv
// A word passes the stage 1, stage 2 and response registers in turn.
// Throughput: one word per cycle while the response channel is ready and
// no clearing pass runs; the frame store read-modify-write runs
// through a single registered-read RAM with write-to-read forwarding.
// Reset: synchronous; afterwards a clearing pass zeroes the frame store,
// one byte a cycle over all FRAME_BYTES addresses (32768 by default), with
// req_chan.ready low. Registers accept writes during the pass.
// ---------------------------------------------------------------------------
// interleaved_frame_blitter_unit
// Maps a byte column and logical row to a banked interleaved frame store
// address and applies a raster operation to the stored byte.
// ---------------------------------------------------------------------------
module interleaved_frame_blitter_unit #(
   parameter int FRAME_BYTES = ifb_pkg::FRAME_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ifb_req_if.sink                        req_chan,
   ifb_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ifb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ifb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ifb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import ifb_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int MOD_W  = SUM_W + 1;
   localparam int EXT_W  = (ADDR_W > RSP_ADDR_W) ? ADDR_W : RSP_ADDR_W;
   localparam logic [MOD_W-1:0]  FRAME_SIZE = MOD_W'(FRAME_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(FRAME_BYTES - 1);

   // ---------------- configuration registers ----------------
   logic                mode_ff;
   logic [COLOUR_W-1:0] ink_ff;
   logic [COLOUR_W-1:0] paper_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         ink_ff   <= 2'd3;
         paper_ff <= 2'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:  mode_ff  <= pwdata[0];
            REG_INK:   ink_ff   <= pwdata[COLOUR_W-1:0];
            REG_PAPER: paper_ff <= pwdata[COLOUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_MODE:  prdata = CSR_DATA_W'(mode_ff);
         REG_INK:   prdata = CSR_DATA_W'(ink_ff);
         REG_PAPER: prdata = CSR_DATA_W'(paper_ff);
         default:   prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic              clear_active_ff;
   logic [ADDR_W-1:0] clear_cnt_ff;
   logic              p1_valid_ff;
   logic              p2_valid_ff;
   logic              rsp_valid_ff;
   logic              out_free;
   logic              p2_free;
   logic              p1_free;
   logic              p1_adv;
   logic              p2_adv;
   logic              accept;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign p2_adv   = p2_valid_ff && out_free;
   assign p2_free  = !p2_valid_ff || out_free;
   assign p1_adv   = p1_valid_ff && p2_free;
   assign p1_free  = !p1_valid_ff || p2_free;
   assign req_chan.ready = !clear_active_ff && p1_free;
   assign accept   = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_cnt_ff    <= '0;
      end else if (clear_active_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == LAST_ADDR) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   // ---------------- stage 0: address sum ----------------
   logic [ROW_W+1:0]   row3;
   logic [1:0]         bank;
   logic [LINE_W-1:0]  line;
   logic [6:0]         stride;
   logic [SUM_W-1:0]   base;
   logic [SUM_W-1:0]   sum_in;

   always_comb begin
      row3 = (ROW_W+2)'(req_chan.row) + (ROW_W+2)'({req_chan.row, 1'b0});
      if (mode_ff) begin
         // display row = row * 3 / 2, four banks
         bank   = row3[2:1];
         line   = row3[ROW_W+1:3];
         stride = MONO_LINE;
         base   = MONO_OFFSET;
      end else begin
         bank   = {1'b0, req_chan.row[0]};
         line   = req_chan.row[ROW_W-1:1];
         stride = COLOUR_LINE;
         base   = '0;
      end
      sum_in = base + (SUM_W'(bank) << BANK_SHIFT)
             + SUM_W'(line) * SUM_W'(stride)
             + SUM_W'(req_chan.pixel_x[PIXEL_X_W-1:2])
             + SUM_W'(req_chan.byte_step);
   end

   logic [SUM_W-1:0]  p1_sum_ff;
   func_type          p1_func_ff;
   logic [BYTE_W-1:0] p1_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_free) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_sum_ff  <= sum_in;
         p1_func_ff <= req_chan.func;
         p1_data_ff <= req_chan.data_in;
      end
   end

   // ---------------- stage 1: wrap and read ----------------
   logic [MOD_W-1:0]  mod_a;
   logic [MOD_W-1:0]  mod_b;
   logic [MOD_W-1:0]  mod_c;
   logic [ADDR_W-1:0] p1_addr;

   // sum stays below three frame sizes: at most two subtractions
   always_comb begin
      mod_a   = MOD_W'(p1_sum_ff);
      mod_b   = (mod_a >= FRAME_SIZE) ? mod_a - FRAME_SIZE : mod_a;
      mod_c   = (mod_b >= FRAME_SIZE) ? mod_b - FRAME_SIZE : mod_b;
      p1_addr = mod_c[ADDR_W-1:0];
   end

   logic [ADDR_W-1:0] p2_addr_ff;
   func_type          p2_func_ff;
   logic [BYTE_W-1:0] p2_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_free) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_adv) begin
         p2_addr_ff <= p1_addr;
         p2_func_ff <= p1_func_ff;
         p2_data_ff <= p1_data_ff;
      end
   end

   // ---------------- frame store ----------------
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;
   logic [BYTE_W-1:0] p2_val;
   logic              p2_wr;

   assign ram_we    = clear_active_ff || (p2_adv && p2_wr);
   assign ram_waddr = clear_active_ff ? clear_cnt_ff : p2_addr_ff;
   assign ram_wdata = clear_active_ff ? '0 : p2_val;

   ifb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (p1_adv),
      .rd_addr (p1_addr),
      .rd_data (ram_rdata)
   );

   // ---------------- stage 2: modify and write back ----------------
   // last written byte, forwarded over a read that raced the write
   logic              wb_valid_ff;
   logic [ADDR_W-1:0] wb_addr_ff;
   logic [BYTE_W-1:0] wb_data_ff;
   logic [BYTE_W-1:0] old_byte;
   logic [BYTE_W-1:0] ink_rep;
   logic [BYTE_W-1:0] paper_rep;

   assign old_byte  = (wb_valid_ff && wb_addr_ff == p2_addr_ff) ? wb_data_ff : ram_rdata;
   assign ink_rep   = rep_colour(ink_ff);
   assign paper_rep = rep_colour(paper_ff);

   always_comb begin
      p2_val = old_byte;
      p2_wr  = 1'b1;
      case (p2_func_ff)
         FUNC_COPY:   p2_val = p2_data_ff;
         FUNC_INVERT: p2_val = ~p2_data_ff;
         FUNC_AND:    p2_val = old_byte & p2_data_ff;
         FUNC_OR:     p2_val = old_byte | p2_data_ff;
         FUNC_XOR:    p2_val = old_byte ^ p2_data_ff;
         FUNC_GLYPH:  p2_val = (p2_data_ff & ink_rep) | (~p2_data_ff & paper_rep);
         FUNC_FILL:   p2_val = ink_rep;
         FUNC_READ: begin
            p2_val = old_byte;
            p2_wr  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (p2_adv && p2_wr) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_adv && p2_wr) begin
         wb_addr_ff <= p2_addr_ff;
         wb_data_ff <= p2_val;
      end
   end

   // ---------------- response register ----------------
   logic [EXT_W-1:0]      addr_ext;
   logic [RSP_ADDR_W-1:0] rsp_address_ff;
   logic [BYTE_W-1:0]     rsp_data_ff;
   logic                  rsp_wrote_ff;

   assign addr_ext = EXT_W'(p2_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_adv) begin
         rsp_address_ff <= addr_ext[RSP_ADDR_W-1:0];
         rsp_data_ff    <= p2_val;
         rsp_wrote_ff   <= p2_wr;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.address  = rsp_address_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.wrote    = rsp_wrote_ff;

`ifndef NO_ASSERTIONS
   // no word may be in flight while the store is being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> (!p1_valid_ff && !p2_valid_ff && !rsp_valid_ff))
      else $error("pipeline busy during clearing pass");

   // clearing pass ends exactly after the last address
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_active_ff) |-> $past(clear_cnt_ff) == LAST_ADDR)
      else $error("clearing pass ended early");

   // a stalled stage 2 word keeps its read data
   a_p2_hold: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && !out_free) |=> (p2_valid_ff && $stable(ram_rdata) && $stable(p2_addr_ff)))
      else $error("stage 2 word lost while stalled");

   // a read word never writes the store
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (p2_adv && p2_func_ff == FUNC_READ && !clear_active_ff) |-> !ram_we)
      else $error("read operation wrote the frame store");
`endif
endmodule

FILE: rtl/ifb_ram.sv
// ---------------------------------------------------------------------------
// ifb_ram
// Simple dual-port RAM, one write and one registered read port,
// read returns the old contents on a same-cycle write.
// ---------------------------------------------------------------------------
module ifb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: tb/sv/tb_interleaved_frame_blitter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_interleaved_frame_blitter_unit
// Drives blit words into the frame blitter and keeps a shadow copy of the
// frame store and the layout registers. Every response word is checked
// against the predicted address, byte and write flag. Both channels stall
// at random, and the registers are rewritten between phases while idle.
// ---------------------------------------------------------------------------
module tb_interleaved_frame_blitter_unit;
   import ifb_pkg::*;

   localparam int          HALF_PERIOD = 2;
   localparam int          STORE_BYTES = FRAME_BYTES_DEF;
   localparam int unsigned BANK_BYTES  = 32'h2000;
   localparam int unsigned MONO_BASE   = 32'h221;
   localparam int unsigned MONO_PITCH  = 90;
   localparam int unsigned CGA_PITCH   = 80;
   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [1:0]  REG_SPARE   = 2'd3;

   typedef struct packed {
      logic [RSP_ADDR_W-1:0] address;
      logic [BYTE_W-1:0]     data_out;
      logic                  wrote;
   } access_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ifb_req_if req_bus ();
   ifb_rsp_if rsp_bus ();

   // shadow of the block's state
   logic [BYTE_W-1:0]   shadow_store [STORE_BYTES];
   logic                mono_layout;
   logic [COLOUR_W-1:0] ink_sel;
   logic [COLOUR_W-1:0] paper_sel;

   access_type expected_access [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   bit      no_gaps     = 1'b0;

   interleaved_frame_blitter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Map the row to the banked address and apply the raster operation.
   function automatic access_type blit_predict(input func_type f,
                                               input logic [PIXEL_X_W-1:0] px,
                                               input logic [STEP_W-1:0] step,
                                               input logic [ROW_W-1:0] row,
                                               input logic [BYTE_W-1:0] d);
      int unsigned       disp;
      int unsigned       addr;
      logic [BYTE_W-1:0] old_byte;
      logic [BYTE_W-1:0] ink_byte;
      logic [BYTE_W-1:0] paper_byte;
      access_type        acc;
      if (mono_layout) begin
         disp = (row * 3) / 2;
         addr = MONO_BASE + BANK_BYTES * (disp % 4) + MONO_PITCH * (disp / 4);
      end else begin
         disp = row;
         addr = BANK_BYTES * (disp % 2) + CGA_PITCH * (disp / 2);
      end
      addr       = (addr + px / 4 + step) % STORE_BYTES;
      old_byte   = shadow_store[addr];
      ink_byte   = {4{ink_sel}};
      paper_byte = {4{paper_sel}};
      acc.wrote  = 1'b1;
      case (f)
         FUNC_COPY:   acc.data_out = d;
         FUNC_INVERT: acc.data_out = ~d;
         FUNC_AND:    acc.data_out = old_byte & d;
         FUNC_OR:     acc.data_out = old_byte | d;
         FUNC_XOR:    acc.data_out = old_byte ^ d;
         FUNC_GLYPH:  acc.data_out = (d & ink_byte) | (~d & paper_byte);
         FUNC_FILL:   acc.data_out = ink_byte;
         default: begin
            acc.data_out = old_byte;
            acc.wrote    = 1'b0;
         end
      endcase
      if (acc.wrote)
         shadow_store[addr] = acc.data_out;
      acc.address = addr[RSP_ADDR_W-1:0];
      return acc;
   endfunction

   task automatic send_word(input func_type f, input logic [PIXEL_X_W-1:0] px,
                            input logic [STEP_W-1:0] step, input logic [ROW_W-1:0] row,
                            input logic [BYTE_W-1:0] d);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 32) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.func      = f;
      req_bus.pixel_x   = px;
      req_bus.byte_step = step;
      req_bus.row       = row;
      req_bus.data_in   = d;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      expected_access.push_back(blit_predict(f, px, step, row, d));
   endtask

   // Drop valid and hold until every response word is back.
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_access.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = {30'd0, value};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (pready !== 1'b1)
         @(posedge clock);
      case (idx)
         REG_MODE:  mono_layout = value[0];
         REG_INK:   ink_sel     = value;
         REG_PAPER: paper_sel   = value;
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_layout(input logic mode, input logic [1:0] ink, input logic [1:0] paper);
      settle();
      csr_write(REG_MODE, {1'b0, mode});
      csr_write(REG_INK, ink);
      csr_write(REG_PAPER, paper);
   endtask

   task automatic test_colour_functions();
      set_layout(1'b0, 2'd3, 2'd0);
      send_word(FUNC_COPY,   10'd0,    8'd0,   9'd0,   8'hA5);
      send_word(FUNC_READ,   10'd0,    8'd0,   9'd0,   8'hFF);
      send_word(FUNC_INVERT, 10'd0,    8'd0,   9'd0,   8'hA5);
      send_word(FUNC_AND,    10'd0,    8'd0,   9'd0,   8'h0F);
      send_word(FUNC_OR,     10'd0,    8'd0,   9'd0,   8'hF0);
      send_word(FUNC_XOR,    10'd0,    8'd0,   9'd0,   8'hFF);
      send_word(FUNC_FILL,   10'd0,    8'd0,   9'd0,   8'h00);
      // full ink, clear paper: the glyph byte lands unchanged
      send_word(FUNC_GLYPH,  10'd0,    8'd0,   9'd0,   8'h3C);
      send_word(FUNC_COPY,   10'd1023, 8'd255, 9'd511, 8'hFF);
      send_word(FUNC_READ,   10'd1023, 8'd255, 9'd511, 8'h5A);
      send_word(FUNC_COPY,   10'd1020, 8'd0,   9'd1,   8'h00);
      send_word(FUNC_XOR,    10'd3,    8'd1,   9'd510, 8'h81);
      settle();
   endtask

   task automatic test_register_extremes();
      set_layout(1'b1, 2'd0, 2'd3);
      // a write past the last register must leave the layout alone
      csr_write(REG_SPARE, 2'd0);
      send_word(FUNC_GLYPH,  10'd40,   8'd0,   9'd0,   8'hF0);
      send_word(FUNC_FILL,   10'd40,   8'd1,   9'd0,   8'hFF);
      // far corner of the tall layout wraps past the end of the store
      send_word(FUNC_COPY,   10'd1023, 8'd255, 9'd511, 8'h7E);
      send_word(FUNC_READ,   10'd1023, 8'd255, 9'd511, 8'h00);
      send_word(FUNC_COPY,   10'd0,    8'd0,   9'd1,   8'h11);
      send_word(FUNC_COPY,   10'd0,    8'd0,   9'd2,   8'h22);
      send_word(FUNC_COPY,   10'd0,    8'd0,   9'd3,   8'h33);
      settle();
      csr_write(REG_INK, 2'd1);
      csr_write(REG_PAPER, 2'd2);
      send_word(FUNC_GLYPH,  10'd0,    8'd0,   9'd3,   8'h33);
      settle();
      csr_write(REG_INK, 2'd2);
      csr_write(REG_PAPER, 2'd1);
      send_word(FUNC_GLYPH,  10'd0,    8'd0,   9'd2,   8'hC3);
      send_word(FUNC_READ,   10'd0,    8'd0,   9'd1,   8'hFF);
      settle();
   endtask

   // Mostly short row spans with random operations, some revisiting the same
   // byte back to back; the rest scattered single words.
   task automatic random_transfers(input int unsigned target);
      int unsigned          sent;
      int unsigned          span;
      logic [PIXEL_X_W-1:0] px;
      logic [STEP_W-1:0]    step;
      logic [ROW_W-1:0]     row;
      sent = 0;
      while (sent < target) begin
         px   = PIXEL_X_W'($urandom_range(1023));
         step = STEP_W'($urandom_range(255));
         row  = ROW_W'($urandom_range(511));
         if ($urandom_range(9) < 7) begin
            span = $urandom_range(16, 1);
            repeat (span) begin
               send_word(func_type'($urandom_range(7)), px, step, row,
                         BYTE_W'($urandom_range(255)));
               sent++;
               if ($urandom_range(3) != 0)
                  step++;
            end
         end else begin
            send_word(func_type'($urandom_range(7)), px, step, row,
                      BYTE_W'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       set_layout(1'b0, 2'd3, 2'd0);
            1:       set_layout(1'b1, 2'd0, 2'd3);
            default: set_layout(1'($urandom_range(1)), 2'($urandom_range(3)),
                                2'($urandom_range(3)));
         endcase
         no_gaps = (p == 2);
         random_transfers(135);
      end
      settle();
      no_gaps = 1'b0;
   endtask

   // response side stalls
   always @(negedge clock)
      rsp_bus.ready = no_gaps || ($urandom_range(99) >= 32);

   always @(posedge clock) begin
      access_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_access.size() == 0) begin
            $error("response word with none pending: address %0h data_out %0h",
                   rsp_bus.address, rsp_bus.data_out);
            fail_count++;
         end else begin
            want = expected_access.pop_front();
            if (rsp_bus.address !== want.address) begin
               $error("address: expected %0h, got %0h", want.address, rsp_bus.address);
               fail_count++;
            end
            if (rsp_bus.data_out !== want.data_out) begin
               $error("data_out: expected %0h, got %0h", want.data_out, rsp_bus.data_out);
               fail_count++;
            end
            if (rsp_bus.wrote !== want.wrote) begin
               $error("wrote: expected %0b, got %0b", want.wrote, rsp_bus.wrote);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_COPY;
      req_bus.pixel_x   = '0;
      req_bus.byte_step = '0;
      req_bus.row       = '0;
      req_bus.data_in   = '0;
      rsp_bus.ready     = 1'b0;
      mono_layout       = 1'b0;
      ink_sel           = 2'd3;
      paper_sel         = 2'd0;
      foreach (shadow_store[i])
         shadow_store[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_colour_functions();
      test_register_extremes();
      test_random_phases();

      while (expected_access.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ifb_pkg.sv
rtl/ifb_req_if.sv
rtl/ifb_rsp_if.sv
rtl/ifb_ram.sv
rtl/interleaved_frame_blitter_unit.sv
tb/sv/tb_interleaved_frame_blitter_unit.sv
